// ===== hw/rtl/ttag_pkg.sv =====
// ----------------------------------------------------------------------------
// ttag_pkg: shared types and constants of the tensor tile address generator
// Default sizes, register indexes, configuration record, controller states
// and the command record passed from controller to datapath.
// ----------------------------------------------------------------------------
package ttag_pkg;

	localparam int DIM_BITS_DEF   = 16;
	localparam int INDEX_BITS_DEF = 32;
	localparam int OUT_W          = 32;
	localparam int FIELD_W        = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int AXES           = 4;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORDER_MODE = 3'd0,
		REG_DIMS_NC    = 3'd1,
		REG_DIM_H      = 3'd2,
		REG_DIM_W      = 3'd3,
		REG_REP_N      = 3'd4,
		REG_REP_C      = 3'd5,
		REG_REP_H      = 3'd6,
		REG_REP_W      = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic               order_mode;
		logic [31:0]        dims_nc;
		logic [FIELD_W-1:0] dim_h;
		logic [FIELD_W-1:0] dim_w;
		logic [FIELD_W-1:0] rep_n;
		logic [FIELD_W-1:0] rep_c;
		logic [FIELD_W-1:0] rep_h;
		logic [FIELD_W-1:0] rep_w;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_COL,
		ST_DONE
	} ctl_state_t;

	// one-hot style strobes from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic step_row;
		logic step_col;
		logic load_out;
	} ctl_cmd_t;

endpackage

// ===== hw/rtl/ttag_if.sv =====
// ----------------------------------------------------------------------------
// ttag_if: request and response channels of the tile address generator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ttag_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface ttag_rsp_if import ttag_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] output_index;
	logic [OUT_W-1:0] source_index;
	logic             last;

	modport source (output valid, output output_index, output source_index, output last,
		input ready);
	modport sink   (input valid, input output_index, input source_index, input last,
		output ready);
endinterface

// ===== hw/rtl/ttag_cfg.sv =====
// ----------------------------------------------------------------------------
// ttag_cfg: configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module ttag_cfg import ttag_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order_mode <= 1'b0;
			cfg_q.dims_nc    <= 32'h0001_0001;
			cfg_q.dim_h      <= FIELD_W'(1);
			cfg_q.dim_w      <= FIELD_W'(1);
			cfg_q.rep_n      <= FIELD_W'(1);
			cfg_q.rep_c      <= FIELD_W'(1);
			cfg_q.rep_h      <= FIELD_W'(1);
			cfg_q.rep_w      <= FIELD_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORDER_MODE: cfg_q.order_mode <= cfg_wdata[0];
				REG_DIMS_NC:    cfg_q.dims_nc    <= cfg_wdata[31:0];
				REG_DIM_H:      cfg_q.dim_h      <= cfg_wdata[FIELD_W-1:0];
				REG_DIM_W:      cfg_q.dim_w      <= cfg_wdata[FIELD_W-1:0];
				REG_REP_N:      cfg_q.rep_n      <= cfg_wdata[FIELD_W-1:0];
				REG_REP_C:      cfg_q.rep_c      <= cfg_wdata[FIELD_W-1:0];
				REG_REP_H:      cfg_q.rep_h      <= cfg_wdata[FIELD_W-1:0];
				REG_REP_W:      cfg_q.rep_w      <= cfg_wdata[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/ttag_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttag_ctrl: sequencing controller
// Steps the datapath through accept, two multiply-add passes and the
// hand-off into the output register; owns both handshakes.
// ----------------------------------------------------------------------------
module ttag_ctrl import ttag_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_ROW;
				end
			end
			ST_ROW: begin
				cmd.step_row = 1'b1;
				state_d      = ST_COL;
			end
			ST_COL: begin
				cmd.step_col = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free or drains this cycle
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/ttag_dp.sv =====
// ----------------------------------------------------------------------------
// ttag_dp: counter and address datapath
// Odometer counters, output position, one shared multiply-add unit that
// builds the source index in Horner form, and the output register.
// ----------------------------------------------------------------------------
module ttag_dp import ttag_pkg::*; #(
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  ctl_cmd_t         cmd,
	input  logic             restart,
	output logic [OUT_W-1:0] output_index,
	output logic [OUT_W-1:0] source_index,
	output logic             last
);

	logic [DIM_BITS-1:0]   inn_q [AXES];
	logic [DIM_BITS-1:0]   rep_q [AXES];
	logic [INDEX_BITS-1:0] pos_q;

	logic [FIELD_W-1:0]    dim_raw [AXES];
	logic [FIELD_W-1:0]    rep_raw [AXES];
	logic [DIM_BITS-1:0]   dl [AXES];
	logic [DIM_BITS-1:0]   rl [AXES];
	logic [DIM_BITS-1:0]   ei [AXES];
	logic [DIM_BITS-1:0]   er [AXES];
	logic [DIM_BITS:0]     ei_inc [AXES];
	logic [DIM_BITS:0]     er_inc [AXES];
	logic                  wi [AXES];
	logic                  wr [AXES];
	logic                  adv_i [AXES];
	logic                  adv_r [AXES];
	logic [AXES:0]         cin;
	logic [INDEX_BITS-1:0] epos;

	logic [INDEX_BITS-1:0] acc_q, oidx_q;
	logic [DIM_BITS-1:0]   i2_q, i3_q;
	logic                  last_q;
	logic [INDEX_BITS-1:0] mul_a, mul_b, mul_c, madd;

	logic [OUT_W-1:0]      oidx_out_q, src_out_q;
	logic                  last_out_q;

	always_comb begin
		dim_raw[0] = cfg.dims_nc[31:16];
		dim_raw[1] = cfg.dims_nc[15:0];
		dim_raw[2] = cfg.dim_h;
		dim_raw[3] = cfg.dim_w;
		rep_raw[0] = cfg.rep_n;
		rep_raw[1] = cfg.rep_c;
		rep_raw[2] = cfg.rep_h;
		rep_raw[3] = cfg.rep_w;
		for (int a = 0; a < AXES; a++) begin
			// a zero field counts as one
			dl[a] = (dim_raw[a][DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : dim_raw[a][DIM_BITS-1:0];
			rl[a] = (rep_raw[a][DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : rep_raw[a][DIM_BITS-1:0];
		end
	end

	// odometer: axis w is least significant; carries ripple toward axis n
	always_comb begin
		cin[AXES] = 1'b1;
		for (int a = AXES - 1; a >= 0; a--) begin
			ei[a]     = restart ? '0 : inn_q[a];
			er[a]     = restart ? '0 : rep_q[a];
			ei_inc[a] = {1'b0, ei[a]} + (DIM_BITS + 1)'(1);
			er_inc[a] = {1'b0, er[a]} + (DIM_BITS + 1)'(1);
			wi[a]     = ei_inc[a] >= {1'b0, dl[a]};
			wr[a]     = er_inc[a] >= {1'b0, rl[a]};
			if (!cfg.order_mode) begin
				adv_r[a] = cin[a+1];
				adv_i[a] = cin[a+1] && wr[a];
			end else begin
				adv_i[a] = cin[a+1];
				adv_r[a] = cin[a+1] && wi[a];
			end
			cin[a] = cin[a+1] && wi[a] && wr[a];
		end
		epos = restart ? '0 : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				inn_q[a] <= '0;
				rep_q[a] <= '0;
			end
			pos_q <= '0;
		end else if (cmd.accept) begin
			if (cin[0]) begin
				// end of tensor: return to the origin
				for (int a = 0; a < AXES; a++) begin
					inn_q[a] <= '0;
					rep_q[a] <= '0;
				end
				pos_q <= '0;
			end else begin
				for (int a = 0; a < AXES; a++) begin
					inn_q[a] <= adv_i[a] ? (wi[a] ? '0 : ei_inc[a][DIM_BITS-1:0]) : ei[a];
					rep_q[a] <= adv_r[a] ? (wr[a] ? '0 : er_inc[a][DIM_BITS-1:0]) : er[a];
				end
				pos_q <= epos + INDEX_BITS'(1);
			end
		end
	end

	// shared multiply-add: acc = acc * dim + counter, starting from n on accept, one pass per cycle
	always_comb begin
		if (cmd.accept) begin
			mul_a = INDEX_BITS'(ei[0]);
			mul_b = INDEX_BITS'(dl[1]);
			mul_c = INDEX_BITS'(ei[1]);
		end else if (cmd.step_row) begin
			mul_a = acc_q;
			mul_b = INDEX_BITS'(dl[2]);
			mul_c = INDEX_BITS'(i2_q);
		end else begin
			mul_a = acc_q;
			mul_b = INDEX_BITS'(dl[3]);
			mul_c = INDEX_BITS'(i3_q);
		end
		madd = (mul_a * mul_b) + mul_c;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			i2_q   <= ei[2];
			i3_q   <= ei[3];
			oidx_q <= epos;
			last_q <= cin[0];
		end
		if (cmd.accept || cmd.step_row || cmd.step_col) begin
			acc_q <= madd;
		end
		if (cmd.load_out) begin
			oidx_out_q <= OUT_W'(oidx_q);
			src_out_q  <= OUT_W'(acc_q);
			last_out_q <= last_q;
		end
	end

	assign output_index = oidx_out_q;
	assign source_index = src_out_q;
	assign last         = last_out_q;

endmodule

// ===== hw/rtl/tensor_tile_address_generator.sv =====
// ----------------------------------------------------------------------------
// tensor_tile_address_generator: tiled 4-D tensor copy address generator
// Flow: a request is accepted in IDLE, ROW and COL finish the source index,
// DONE loads the output register once it is free. The shared multiply-add
// unit makes three Horner passes over the source index; requests wait for it.
// Reset: registers return to their defaults, counters and position to zero.
// ----------------------------------------------------------------------------
module tensor_tile_address_generator import ttag_pkg::*; #(
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ttag_req_if.sink              req,
	ttag_rsp_if.source            rsp
);

	cfg_t     cfg;
	ctl_cmd_t cmd;

	// The user must write configuration only while no beat is in flight; the block does not enforce this.
	ttag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Controller: takes a request beat in idle, sequences the two remaining
	// multiply-add passes, then moves the result into the output register.
	// A finished result may sit in the output register while the next request
	// is already being worked on.
	ttag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// Datapath: on accept, clear on restart, latch the output position and the
	// last flag, advance the odometer, and start the source index with
	// n*C + c; the next passes fold in h and w.
	ttag_dp #(
		.DIM_BITS   (DIM_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.restart      (req.restart),
		.output_index (rsp.output_index),
		.source_index (rsp.source_index),
		.last         (rsp.last)
	);

endmodule

// ===== dv/tb_tensor_tile_address_generator.sv =====
// ----------------------------------------------------------------------------
// tb_tensor_tile_address_generator: self-checking bench of the tile address generator
// Walks a short table of directed requests and register settings, then random
// register phases with mostly unbroken runs of requests. Every response beat
// is compared field by field against a typed table beat or a cycle-free model
// of the 4-D tiling odometer kept in the bench. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_tensor_tile_address_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import ttag_pkg::*;

	localparam int RAND_ITEMS  = 750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL  = 80;

	typedef struct packed {
		logic [OUT_W-1:0] output_index;
		logic [OUT_W-1:0] source_index;
		logic             last;
	} tile_beat_t;

	// one line of the directed table: either a register write or a request
	typedef struct {
		bit          is_cfg;
		cfg_reg_t    idx;
		logic [31:0] wdata;
		bit          restart;
		bit          typed;
		tile_beat_t  want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ttag_req_if req_ch ();
	ttag_rsp_if rsp_ch ();

	tensor_tile_address_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	// model state: register copy, odometer counters and output position
	cfg_t        mdl_cfg;
	logic [15:0] inner_ctr [4];
	logic [15:0] rep_ctr   [4];
	logic [31:0] out_pos;

	tile_beat_t pending_beats [$];
	dir_row_t   dir_rows [$];

	int  mismatches = 0;
	int  requests   = 0;
	int  results    = 0;
	int  tensor_ends = 0;
	int  cfg_writes = 0;
	int  cycle_count = 0;
	bit  quiet = 1'b0;
	bit  stall_pending = 1'b0;

	// a zero dimension or repeat count behaves as one
	function automatic int unsigned axis_limit(logic [15:0] v);
		return (v == 16'd0) ? 32'd1 : {16'd0, v};
	endfunction

	// advance one counter, returning {carry, next value}; a counter that
	// stands at or above its limit carries on this advance
	function automatic logic [16:0] bump(logic [15:0] c, int unsigned lim);
		if ({16'd0, c} + 32'd1 >= lim)
			return {1'b1, 16'd0};
		return {1'b0, c + 16'd1};
	endfunction

	task automatic clear_model_counters();
		for (int a = 0; a < AXES; a++) begin
			inner_ctr[a] = 16'd0;
			rep_ctr[a]   = 16'd0;
		end
		out_pos = 32'd0;
	endtask

	// compute the beat for one request and advance the odometer from w down to n
	task automatic tile_predict(input bit restart, output tile_beat_t beat);
		int unsigned dl [4];
		int unsigned rl [4];
		bit [63:0]   src;
		bit          carry;
		dl[0] = axis_limit(mdl_cfg.dims_nc[31:16]);
		dl[1] = axis_limit(mdl_cfg.dims_nc[15:0]);
		dl[2] = axis_limit(mdl_cfg.dim_h);
		dl[3] = axis_limit(mdl_cfg.dim_w);
		rl[0] = axis_limit(mdl_cfg.rep_n);
		rl[1] = axis_limit(mdl_cfg.rep_c);
		rl[2] = axis_limit(mdl_cfg.rep_h);
		rl[3] = axis_limit(mdl_cfg.rep_w);
		if (restart)
			clear_model_counters();
		src = inner_ctr[0] * dl[1] * dl[2] * dl[3] + inner_ctr[1] * dl[2] * dl[3]
			+ inner_ctr[2] * dl[3] + inner_ctr[3];
		beat.output_index = out_pos;
		beat.source_index = src[31:0];
		carry = 1'b1;
		for (int a = AXES - 1; a >= 0; a--) begin
			if (carry) begin
				if (!mdl_cfg.order_mode) begin
					// inner index outside its repeat: elements repeat in place
					{carry, rep_ctr[a]} = bump(rep_ctr[a], rl[a]);
					if (carry)
						{carry, inner_ctr[a]} = bump(inner_ctr[a], dl[a]);
				end else begin
					// repeat outside the inner index: whole blocks repeat
					{carry, inner_ctr[a]} = bump(inner_ctr[a], dl[a]);
					if (carry)
						{carry, rep_ctr[a]} = bump(rep_ctr[a], rl[a]);
				end
			end
		end
		if (carry) begin
			beat.last = 1'b1;
			clear_model_counters();
		end else begin
			beat.last = 1'b0;
			out_pos = out_pos + 32'd1;
		end
	endtask

	// write one register; leave cfg_we high, the caller drops it after the batch
	task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			REG_ORDER_MODE: mdl_cfg.order_mode = v[0];
			REG_DIMS_NC:    mdl_cfg.dims_nc    = v;
			REG_DIM_H:      mdl_cfg.dim_h      = v[15:0];
			REG_DIM_W:      mdl_cfg.dim_w      = v[15:0];
			REG_REP_N:      mdl_cfg.rep_n      = v[15:0];
			REG_REP_C:      mdl_cfg.rep_c      = v[15:0];
			REG_REP_H:      mdl_cfg.rep_h      = v[15:0];
			REG_REP_W:      mdl_cfg.rep_w      = v[15:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// offer one request and hold it until it is taken; queue its expected beat
	task automatic offer_request(input bit restart, input bit typed, input tile_beat_t want);
		tile_beat_t beat;
		req_ch.valid   <= 1'b1;
		req_ch.restart <= restart;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tile_predict(restart, beat);
		pending_beats.push_back(typed ? want : beat);
		requests++;
	endtask

	// drop valid and hold until every queued beat has come back
	task automatic wait_for_beats_out();
		req_ch.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	function automatic void row_cfg(cfg_reg_t idx, logic [31:0] v);
		dir_row_t r;
		r.is_cfg  = 1'b1;
		r.idx     = idx;
		r.wdata   = v;
		r.restart = 1'b0;
		r.typed   = 1'b0;
		r.want    = '0;
		dir_rows.push_back(r);
	endfunction

	// typed == 0: the model supplies the expected beat
	function automatic void row_req(bit restart, bit typed, logic [31:0] oi, logic [31:0] si,
		bit last);
		dir_row_t r;
		r.is_cfg  = 1'b0;
		r.idx     = REG_ORDER_MODE;
		r.wdata   = '0;
		r.restart = restart;
		r.typed   = typed;
		r.want    = '{output_index: oi, source_index: si, last: last};
		dir_rows.push_back(r);
	endfunction

	// mostly tiny sizes so tensors end often; now and then zero, full or wild values
	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 14))
			0:             return 32'd0;
			1:             return $urandom;
			2:             return 32'h0000_FFFF;
			3, 4, 5, 6, 7, 8: return 32'd1;
			default:       return $urandom_range(2, 3);
		endcase
	endfunction

	// response checker: compare every accepted beat with the oldest expectation
	always @(posedge clk) begin
		tile_beat_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual oi=%h si=%h last=%b",
					$time, rsp_ch.output_index, rsp_ch.source_index, rsp_ch.last);
				mismatches++;
			end else begin
				want = pending_beats.pop_front();
				if (rsp_ch.output_index !== want.output_index) begin
					$display("%0t: output_index expected %h actual %h", $time,
						want.output_index, rsp_ch.output_index);
					mismatches++;
				end
				if (rsp_ch.source_index !== want.source_index) begin
					$display("%0t: source_index expected %h actual %h", $time,
						want.source_index, rsp_ch.source_index);
					mismatches++;
				end
				if (rsp_ch.last !== want.last) begin
					$display("%0t: last expected %b actual %b", $time, want.last, rsp_ch.last);
					mismatches++;
				end
			end
			results++;
			if (rsp_ch.last === 1'b1)
				tensor_ends++;
		end
	end

	// response side: random ready bursts, one long hold-off on request, none when quiet
	initial begin
		int hold;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_pending) begin
				// hold off long enough for the block to back up into the request side
				stall_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				hold = 0;
				while (hold < LONG_STALL) begin
					@(posedge clk);
					hold++;
				end
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus
	initial begin
		dir_row_t    row;
		bit          in_cfg;
		bit          gappy;
		bit          rst;
		int          rand_sent;
		int          phase;
		int          kind;
		int          len;
		cfg_reg_t    ri;
		logic [31:0] v;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_ORDER_MODE;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.restart = 1'b0;

		// register defaults after reset
		mdl_cfg.order_mode = 1'b0;
		mdl_cfg.dims_nc    = 32'h0001_0001;
		mdl_cfg.dim_h      = 16'd1;
		mdl_cfg.dim_w      = 16'd1;
		mdl_cfg.rep_n      = 16'd1;
		mdl_cfg.rep_c      = 16'd1;
		mdl_cfg.rep_h      = 16'd1;
		mdl_cfg.rep_w      = 16'd1;
		clear_model_counters();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the tensor is one element: every beat is index 0 and last
		row_req(1'b0, 1'b1, 32'd0, 32'd0, 1'b1);
		row_req(1'b1, 1'b1, 32'd0, 32'd0, 1'b1);
		// zero sizes count as one, so the tensor stays a single element
		row_cfg(REG_DIM_W, 32'd0);
		row_cfg(REG_DIMS_NC, 32'd0);
		row_cfg(REG_REP_N, 32'd0);
		row_req(1'b0, 1'b1, 32'd0, 32'd0, 1'b1);
		// width 3 repeated twice, elements repeat in place
		row_cfg(REG_DIMS_NC, 32'h0001_0001);
		row_cfg(REG_DIM_W, 32'd3);
		row_cfg(REG_REP_W, 32'd2);
		row_cfg(REG_ORDER_MODE, 32'd0);
		row_req(1'b0, 1'b1, 32'd0, 32'd0, 1'b0);
		row_req(1'b0, 1'b1, 32'd1, 32'd0, 1'b0);
		row_req(1'b0, 1'b1, 32'd2, 32'd1, 1'b0);
		row_req(1'b0, 1'b1, 32'd3, 32'd1, 1'b0);
		row_req(1'b0, 1'b1, 32'd4, 32'd2, 1'b0);
		row_req(1'b0, 1'b1, 32'd5, 32'd2, 1'b1);
		// block order: the whole row repeats
		row_cfg(REG_ORDER_MODE, 32'd1);
		row_req(1'b0, 1'b1, 32'd0, 32'd0, 1'b0);
		row_req(1'b0, 1'b1, 32'd1, 32'd1, 1'b0);
		row_req(1'b0, 1'b1, 32'd2, 32'd2, 1'b0);
		// restart in the middle of the tensor
		row_req(1'b1, 1'b1, 32'd0, 32'd0, 1'b0);
		row_req(1'b0, 1'b0, 32'd0, 32'd0, 1'b0);
		// shrink the width mid-tensor: the counter stands above its new limit
		row_cfg(REG_DIM_W, 32'd1);
		row_req(1'b0, 1'b0, 32'd0, 32'd0, 1'b0);
		row_req(1'b0, 1'b0, 32'd0, 32'd0, 1'b0);
		// walk the batch counter up, then blow the sizes up so the source index wraps
		row_cfg(REG_ORDER_MODE, 32'hFFFF_FFFE);
		row_cfg(REG_REP_W, 32'd1);
		row_cfg(REG_DIMS_NC, 32'hFFFF_0001);
		row_req(1'b1, 1'b1, 32'd0, 32'd0, 1'b0);
		row_req(1'b0, 1'b1, 32'd1, 32'd1, 1'b0);
		row_req(1'b0, 1'b1, 32'd2, 32'd2, 1'b0);
		row_cfg(REG_DIMS_NC, 32'hFFFF_FFFF);
		row_cfg(REG_DIM_H, 32'h0000_FFFF);
		row_cfg(REG_DIM_W, 32'h0000_FFFF);
		row_cfg(REG_REP_N, 32'h0000_FFFF);
		row_cfg(REG_REP_C, 32'h0000_FFFF);
		row_cfg(REG_REP_H, 32'h0000_FFFF);
		row_cfg(REG_REP_W, 32'h0000_FFFF);
		row_req(1'b0, 1'b0, 32'd0, 32'd0, 1'b0);
		row_req(1'b0, 1'b0, 32'd0, 32'd0, 1'b0);
		// upper data bits above a 16-bit register are dropped
		row_cfg(REG_DIM_H, 32'hABCD_0005);
		row_cfg(REG_REP_C, 32'h5432_0003);
		row_req(1'b0, 1'b0, 32'd0, 32'd0, 1'b0);
		row_req(1'b0, 1'b0, 32'd0, 32'd0, 1'b0);

		// walk the table; register rows only run once the block has drained
		in_cfg = 1'b0;
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_cfg) begin
				if (!in_cfg)
					wait_for_beats_out();
				in_cfg = 1'b1;
				cfg_write(row.idx, row.wdata);
			end else begin
				if (in_cfg)
					cfg_we <= 1'b0;
				in_cfg = 1'b0;
				offer_request(row.restart, row.typed, row.want);
			end
		end

		// random phases: new registers on a drained block, then a run of requests
		rand_sent = 0;
		phase = 0;
		while (rand_sent < RAND_ITEMS) begin
			wait_for_beats_out();
			kind = phase % 7;
			for (int i = 0; i < 8; i++) begin
				ri = cfg_reg_t'(i);
				if (kind == 0) begin
					// every size at its maximum
					v = (ri == REG_ORDER_MODE) ? 32'd1 :
						(ri == REG_DIMS_NC) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
					cfg_write(ri, v);
				end else if (kind == 1) begin
					// every size at its minimum
					v = (ri == REG_ORDER_MODE) ? 32'd0 :
						(ri == REG_DIMS_NC) ? 32'h0001_0001 : 32'd1;
					cfg_write(ri, v);
				end else if ($urandom_range(0, 2) != 0) begin
					if (ri == REG_ORDER_MODE)
						v = $urandom;
					else if (ri == REG_DIMS_NC)
						v = ($urandom_range(0, 7) == 0) ? $urandom :
							((rand_field() << 16) | (rand_field() & 32'h0000_FFFF));
					else
						v = rand_field();
					cfg_write(ri, v);
				end
			end
			cfg_we <= 1'b0;

			gappy = !quiet && ($urandom_range(0, 3) != 0);
			len = $urandom_range(10, 40);
			if (phase == 2) begin
				// back-to-back requests against a long response hold-off
				stall_pending = 1'b1;
				gappy = 1'b0;
				len = 40;
			end
			for (int k = 0; k < len; k++) begin
				// mostly unbroken runs; restart at a phase start or rarely mid-run
				rst = (k == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 24) == 0);
				offer_request(rst, 1'b0, '0);
				rand_sent++;
				if (phase == 4 && k == len / 2) begin
					wait_for_beats_out();
				end else if (gappy && !quiet && $urandom_range(0, 2) == 0) begin
					req_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 11)) @(posedge clk);
				end
			end
			phase++;
			quiet = (rand_sent >= RAND_ITEMS - 100);
		end

		// drain, then keep the clock running so any stray beat can still show
		wait_for_beats_out();
		repeat (8) @(posedge clk);

		$display("covered %0d requests in %0d directed rows and %0d random phases, %0d reg writes",
			requests, dir_rows.size(), phase, cfg_writes);
		$display("checked %0d response beats, %0d tensor ends, %0d mismatches",
			results, tensor_ends, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
